>>> sv/iecho_pkg.sv
// ----------------------------------------------------------------------------
// iecho_pkg: shared types and constants of the ICMP echo reply reflector
// Frame positions, state encoding and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package iecho_pkg;

  localparam int IDX_W            = 6;
  localparam int WORD_W           = 16;
  localparam int BV_W             = 2;
  localparam int HOLD_WORDS_DEF   = 37;
  localparam int ETH_HEADER_WORDS = 7;

  localparam logic [IDX_W-1:0] ETH_POS       = IDX_W'(ETH_HEADER_WORDS);
  localparam logic [IDX_W-1:0] CSUM_POS      = IDX_W'(ETH_HEADER_WORDS + 5);
  localparam logic [IDX_W-1:0] IPSRC_POS     = IDX_W'(ETH_HEADER_WORDS + 6);
  localparam logic [IDX_W-1:0] ICMP_TYPE_POS = IDX_W'(ETH_HEADER_WORDS + 10);
  localparam logic [IDX_W-1:0] INDEX_MAX     = '1;

  localparam logic [BV_W-1:0] BV_ONE = 2'd1;
  localparam logic [BV_W-1:0] BV_TWO = 2'd2;

  typedef enum logic [3:0] {
    ST_HOLD = 4'b0001,
    ST_READ = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_PASS = 4'b1000
  } iecho_state_t;

  typedef struct packed {
    logic hold_acc;
    logic rd_en;
    logic load;
    logic pass_acc;
  } iecho_cmd_t;

  typedef struct packed {
    logic release_hdr;
    logic drain_final;
    logic frame_end;
    logic in_last;
    logic out_free;
  } iecho_status_t;

endpackage

>>> sv/iecho_dp.sv
// ----------------------------------------------------------------------------
// iecho_dp: datapath of the ICMP echo reply reflector
// Header store, checksum accumulation, header length capture, held-word
// rewrite and the output register.
// ----------------------------------------------------------------------------
module iecho_dp
  import iecho_pkg::*;
#(
  parameter int HOLD_WORDS = HOLD_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  iecho_cmd_t          cmd,
  output iecho_status_t       status,
  input  logic [WORD_W-1:0]   in_data_word,
  input  logic [BV_W-1:0]     in_bytes_valid,
  input  logic                in_last_word,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [WORD_W-1:0]   out_word,
  output logic [BV_W-1:0]     out_bytes_valid,
  output logic                out_last
);

  localparam int AW = (HOLD_WORDS > 1) ? $clog2(HOLD_WORDS) : 1;
  localparam logic [IDX_W-1:0] HOLD_W = IDX_W'(HOLD_WORDS);

  logic [WORD_W-1:0] mem [HOLD_WORDS];

  logic [IDX_W-1:0]  word_index_r, word_index_nxt;
  logic [IDX_W-1:0]  header_words_r, header_words_nxt;
  logic [WORD_W-1:0] csum_r, csum_nxt;
  logic [IDX_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  q_r, q_nxt;
  logic              drain_last_r, drain_last_nxt;
  logic [BV_W-1:0]   last_bv_r, last_bv_nxt;
  logic [WORD_W-1:0] rd_data_r;
  logic [IDX_W-1:0]  rd_pos_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_word_r, out_word_nxt;
  logic [BV_W-1:0]   out_bv_r, out_bv_nxt;
  logic              out_last_r, out_last_nxt;

  logic [BV_W-1:0]   bv_in;
  logic [WORD_W-1:0] w_in;
  logic [3:0]        ihl_eff;
  logic [IDX_W:0]    hw_calc;
  logic [IDX_W-1:0]  hw_new;
  logic [IDX_W-1:0]  hw_eff;
  logic [IDX_W:0]    p_inc;
  logic [WORD_W:0]   sum17;
  logic [WORD_W-1:0] csum_fold;
  logic [IDX_W-1:0]  src;
  logic [WORD_W-1:0] drain_word;
  logic              drain_fin;
  logic [BV_W-1:0]   drain_bv;
  logic [WORD_W-1:0] pass_word;

  function automatic logic [IDX_W-1:0] partner(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    r = p;
    if (p < IDX_W'(3)) r = p + IDX_W'(3);
    else if (p < IDX_W'(6)) r = p - IDX_W'(3);
    else if (p == IPSRC_POS || p == IPSRC_POS + IDX_W'(1)) r = p + IDX_W'(2);
    else if (p == IPSRC_POS + IDX_W'(2) || p == IPSRC_POS + IDX_W'(3)) r = p - IDX_W'(2);
    return r;
  endfunction

  always_comb begin
    bv_in = (in_last_word && in_bytes_valid == BV_ONE) ? BV_ONE : BV_TWO;
    w_in  = (bv_in == BV_ONE) ? {in_data_word[15:8], 8'h00} : in_data_word;
    ihl_eff = (w_in[11:8] < 4'd5) ? 4'd5 : w_in[11:8];
    hw_calc = (IDX_W+1)'(ETH_HEADER_WORDS) + {{(IDX_W-4){1'b0}}, ihl_eff, 1'b0};
    hw_new  = (hw_calc > {1'b0, HOLD_W}) ? HOLD_W : hw_calc[IDX_W-1:0];
    hw_eff  = (word_index_r == ETH_POS) ? hw_new : header_words_r;
    p_inc   = {1'b0, word_index_r} + (IDX_W+1)'(1);
    sum17   = {1'b0, csum_r} + {1'b0, w_in};
    csum_fold = sum17[WORD_W-1:0] + WORD_W'(sum17[WORD_W]);
    src = partner(q_r);
    if (src >= count_r) src = q_r;

    drain_word = rd_data_r;
    if (rd_pos_r == CSUM_POS) drain_word = ~csum_r;
    if (rd_pos_r == ICMP_TYPE_POS) drain_word = drain_word & 16'h00FF;
    drain_fin = drain_last_r && (rd_pos_r + IDX_W'(1) == count_r);
    drain_bv  = drain_fin ? last_bv_r : BV_TWO;
    if (drain_bv == BV_ONE) drain_word = drain_word & 16'hFF00;

    pass_word = (word_index_r == ICMP_TYPE_POS) ? (w_in & 16'h00FF) : w_in;
  end

  always_comb begin
    status.release_hdr = in_last_word || (p_inc >= {1'b0, hw_eff});
    status.drain_final = (q_r + IDX_W'(1) == count_r);
    status.frame_end   = drain_last_r;
    status.in_last     = in_last_word;
    status.out_free    = !out_valid_r || out_ready;
  end

  always_comb begin
    word_index_nxt   = word_index_r;
    header_words_nxt = header_words_r;
    csum_nxt         = csum_r;
    count_nxt        = count_r;
    q_nxt            = q_r;
    drain_last_nxt   = drain_last_r;
    last_bv_nxt      = last_bv_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_word_nxt     = out_word_r;
    out_bv_nxt       = out_bv_r;
    out_last_nxt     = out_last_r;

    if (cmd.hold_acc) begin
      word_index_nxt = p_inc[IDX_W-1:0];
      if (word_index_r == ETH_POS) header_words_nxt = hw_new;
      if (word_index_r >= ETH_POS && word_index_r != CSUM_POS) csum_nxt = csum_fold;
      if (status.release_hdr) begin
        count_nxt      = p_inc[IDX_W-1:0];
        q_nxt          = '0;
        drain_last_nxt = in_last_word;
        last_bv_nxt    = bv_in;
      end
    end

    if (cmd.load) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = drain_word;
      out_bv_nxt    = drain_bv;
      out_last_nxt  = drain_fin;
      q_nxt         = q_r + IDX_W'(1);
      if (status.drain_final && drain_last_r) begin
        word_index_nxt   = '0;
        header_words_nxt = HOLD_W;
        csum_nxt         = '0;
      end
    end

    if (cmd.pass_acc) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = pass_word;
      out_bv_nxt    = bv_in;
      out_last_nxt  = in_last_word;
      if (in_last_word) begin
        word_index_nxt   = '0;
        header_words_nxt = HOLD_W;
        csum_nxt         = '0;
      end else if (word_index_r < INDEX_MAX) begin
        word_index_nxt = word_index_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_index_r   <= '0;
      header_words_r <= HOLD_W;
      csum_r         <= '0;
      count_r        <= '0;
      q_r            <= '0;
      drain_last_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      word_index_r   <= word_index_nxt;
      header_words_r <= header_words_nxt;
      csum_r         <= csum_nxt;
      count_r        <= count_nxt;
      q_r            <= q_nxt;
      drain_last_r   <= drain_last_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_bv_r  <= last_bv_nxt;
    out_word_r <= out_word_nxt;
    out_bv_r   <= out_bv_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_acc) mem[word_index_r[AW-1:0]] <= w_in;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[src[AW-1:0]];
      rd_pos_r  <= q_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;
  assign out_bytes_valid = out_bv_r;
  assign out_last        = out_last_r;

  a_no_hold_during_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hold_acc |-> !cmd.load && !cmd.pass_acc)
    else $error("hold accept overlaps output load");

  a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> q_r < count_r)
    else $error("drain read past held words");

  a_pass_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pass_acc |-> word_index_r >= ICMP_TYPE_POS)
    else $error("pass-through before header release");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && status.drain_final && drain_last_r |=> word_index_r == '0 && csum_r == '0)
    else $error("state not cleared after short frame");

endmodule

>>> sv/iecho_ctrl.sv
// ----------------------------------------------------------------------------
// iecho_ctrl: controller of the ICMP echo reply reflector
// Sequences header hold, held-word drain and pass-through of the payload.
// ----------------------------------------------------------------------------
module iecho_ctrl
  import iecho_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  iecho_status_t status,
  output iecho_cmd_t    cmd
);

  iecho_state_t st_r, st_nxt;

  always_comb begin
    in_ready     = 1'b0;
    cmd.hold_acc = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.load     = 1'b0;
    cmd.pass_acc = 1'b0;
    st_nxt       = st_r;
    case (st_r)
      ST_HOLD: begin
        in_ready     = 1'b1;
        cmd.hold_acc = in_valid;
        if (in_valid && status.release_hdr) st_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        st_nxt    = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load = status.out_free;
        if (status.out_free) begin
          if (!status.drain_final) st_nxt = ST_READ;
          else if (status.frame_end) st_nxt = ST_HOLD;
          else st_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        in_ready     = status.out_free;
        cmd.pass_acc = in_valid && status.out_free;
        if (cmd.pass_acc && status.in_last) st_nxt = ST_HOLD;
      end
      default: st_nxt = ST_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_HOLD;
    end else begin
      st_r <= st_nxt;
    end
  end

  a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> st_r == ST_LOAD)
    else $error("drain read not followed by load");

  a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en || st_r == ST_LOAD |-> !cmd.hold_acc && !cmd.pass_acc)
    else $error("input taken during drain");

  a_release_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hold_acc && status.release_hdr |=> cmd.rd_en)
    else $error("header release did not start drain");

endmodule

>>> sv/icmp_echo_reply_reflector.sv
// ----------------------------------------------------------------------------
// icmp_echo_reply_reflector: ping request to echo reply frame rewrite
// Holds the Ethernet and IP header of a frame, then emits it with MAC and IP
// addresses swapped, the ICMP type cleared and the IP header checksum redone.
// ----------------------------------------------------------------------------
// Header words are taken one per cycle while the IP header is collected. Once
// the header is complete (7 + 2*IHL words, at most HOLD_WORDS) or the frame
// ends, the held words are sent out one by one, each read from the header
// store and then loaded into the output register, which can stall on out_ready.
// Words after the header pass through at one word per cycle while the output
// register is free. No input is taken during the release of the held words.
// The header store needs no clearing after reset.
module icmp_echo_reply_reflector
  import iecho_pkg::*;
#(
  parameter int HOLD_WORDS = HOLD_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [WORD_W-1:0] in_data_word,
  input  logic [BV_W-1:0]   in_bytes_valid,
  input  logic              in_last_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_word,
  output logic [BV_W-1:0]   out_bytes_valid,
  output logic              out_last
);

  iecho_cmd_t    cmd;
  iecho_status_t status;

  iecho_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  iecho_dp #(
    .HOLD_WORDS (HOLD_WORDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_data_word    (in_data_word),
    .in_bytes_valid  (in_bytes_valid),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .out_bytes_valid (out_bytes_valid),
    .out_last        (out_last)
  );

endmodule

>>> test/icmp_echo_reply_reflector_tb.sv
// ----------------------------------------------------------------------------
// icmp_echo_reply_reflector_tb: self-checking bench for the echo reply rewrite
// Sends Ethernet/IPv4 frames word by word and predicts the rewritten frame:
// MAC and IP swaps, cleared ICMP type, fresh IP header checksum, short and
// long frames, odd last words. Runs under several sender and receiver idle
// patterns, one long receiver hold-off, and compares every output word.
// ----------------------------------------------------------------------------
module icmp_echo_reply_reflector_tb;
  import iecho_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 100;
  localparam int MAC_WORDS       = 3;
  localparam logic [3:0] IPV4_VER      = 4'h4;
  localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;
  localparam logic [BV_W-1:0] BV_RSVD0 = 2'd0;
  localparam logic [BV_W-1:0] BV_RSVD3 = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [BV_W-1:0]   bv;
    logic              last;
  } frame_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [WORD_W-1:0] in_data_word = '0;
  logic [BV_W-1:0]   in_bytes_valid = BV_TWO;
  logic              in_last_word = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] out_word;
  logic [BV_W-1:0]   out_bytes_valid;
  logic              out_last;

  frame_word_t pending_words[$];
  frame_word_t reply_words[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          queued_cnt = 0;
  int          error_cnt = 0;
  logic        hold_go = 1'b0;
  logic        hold_off = 1'b0;

  logic [WORD_W-1:0] hdr_store [HOLD_WORDS_DEF];
  logic [IDX_W-1:0]  word_idx;
  logic [IDX_W-1:0]  hdr_words;
  logic [16:0]       csum_acc;
  logic              released;

  icmp_echo_reply_reflector dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_bytes_valid  (in_bytes_valid),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .out_bytes_valid (out_bytes_valid),
    .out_last        (out_last)
  );

  always #CLK_HALF clk = ~clk;

  function automatic void clear_frame();
    word_idx  = '0;
    hdr_words = IDX_W'(HOLD_WORDS_DEF);
    csum_acc  = '0;
    released  = 1'b0;
  endfunction

  // Predict the reply words caused by one accepted request.
  function automatic void reflect_word(input frame_word_t req);
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] v;
    logic [BV_W-1:0]   bv;
    logic [BV_W-1:0]   obv;
    int                p;
    int                ihl;
    int                hw;
    int                src;
    int                cnt;
    logic              fin;
    bv = (req.last && req.bv == BV_ONE) ? BV_ONE : BV_TWO;
    w  = req.word;
    if (bv == BV_ONE) w &= 16'hFF00;
    p = word_idx;
    if (released) begin
      if (p == ICMP_TYPE_POS) w &= 16'h00FF;
      reply_words.push_back('{w, bv, req.last});
      if (req.last) clear_frame();
      else if (word_idx != INDEX_MAX) word_idx++;
      return;
    end
    hdr_store[p] = w;
    if (p == ETH_POS) begin
      ihl = w[11:8];
      if (ihl < 5) ihl = 5;
      hw = ETH_HEADER_WORDS + 2 * ihl;
      hdr_words = IDX_W'((hw > HOLD_WORDS_DEF) ? HOLD_WORDS_DEF : hw);
    end
    if (p >= ETH_POS && p < hdr_words && p != CSUM_POS) begin
      csum_acc = csum_acc + {1'b0, w};
      csum_acc = {1'b0, csum_acc[15:0]} + 17'(csum_acc[16]);
    end
    if (req.last || p + 1 >= hdr_words) begin
      cnt = p + 1;
      for (int q = 0; q < cnt; q++) begin
        if (q < MAC_WORDS) src = q + MAC_WORDS;
        else if (q < 2 * MAC_WORDS) src = q - MAC_WORDS;
        else if (q == IPSRC_POS || q == IPSRC_POS + 1) src = q + 2;
        else if (q == IPSRC_POS + 2 || q == IPSRC_POS + 3) src = q - 2;
        else src = q;
        if (src >= cnt) src = q;
        v   = hdr_store[src];
        fin = req.last && (q + 1 == cnt);
        obv = fin ? bv : BV_TWO;
        if (q == CSUM_POS) v = ~csum_acc[15:0];
        if (q == ICMP_TYPE_POS) v &= 16'h00FF;
        if (obv == BV_ONE) v &= 16'hFF00;
        reply_words.push_back('{v, obv, fin});
      end
      if (req.last) clear_frame();
      else begin
        released = 1'b1;
        word_idx = IDX_W'(cnt);
      end
    end else begin
      word_idx = IDX_W'(p + 1);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  // Driver: offer the next pending request, predict on acceptance.
  always @(posedge clk) begin : driver
    frame_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_frame();
    end else begin
      if (in_valid && in_ready)
        reflect_word('{in_data_word, in_bytes_valid, in_last_word});
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_words.pop_front();
          in_valid       <= 1'b1;
          in_data_word   <= nxt.word;
          in_bytes_valid <= nxt.bv;
          in_last_word   <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each reply word against the oldest prediction.
  always @(posedge clk) begin : monitor
    frame_word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reply_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_word));
        end else begin
          exp_w = reply_words.pop_front();
          if (out_word !== exp_w.word)
            report_mismatch($sformatf("word %h, want %h", out_word, exp_w.word));
          if (out_bytes_valid !== exp_w.bv)
            report_mismatch($sformatf("bytes_valid %0d, want %0d", out_bytes_valid, exp_w.bv));
          if (out_last !== exp_w.last)
            report_mismatch($sformatf("last %b, want %b", out_last, exp_w.last));
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : hold_off_timer
    wait (hold_go);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic queue_fill(input int len, input logic [WORD_W-1:0] fill,
                            input logic [BV_W-1:0] mid_bv, input logic [BV_W-1:0] last_bv);
    for (int i = 0; i < len; i++) begin
      pending_words.push_back('{fill, (i == len - 1) ? last_bv : mid_bv, i == len - 1});
      queued_cnt++;
    end
  endtask

  task automatic queue_frame(input int len, input int ihl, input bit odd_end, input bit noise);
    frame_word_t w;
    for (int i = 0; i < len; i++) begin
      w.word = 16'($urandom());
      if (!noise && i == ETH_POS) w.word[15:8] = {IPV4_VER, 4'(ihl)};
      if (!noise && i == ICMP_TYPE_POS) w.word[15:8] = ICMP_ECHO_REQ;
      w.last = (i == len - 1);
      if (w.last && odd_end) w.bv = BV_ONE;
      else if (noise) w.bv = 2'($urandom_range(3));
      else w.bv = BV_TWO;
      pending_words.push_back(w);
      queued_cnt++;
    end
  endtask

  task automatic queue_random_frame();
    int pick;
    int ihl;
    int hw;
    int len;
    pick = $urandom_range(99);
    ihl  = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
    hw   = ETH_HEADER_WORDS + 2 * ((ihl < 5) ? 5 : ihl);
    if (pick < 5) len = $urandom_range(80, 64);
    else if (pick < 20) len = $urandom_range(hw - 1, 1);
    else if (pick < 90) len = hw + (($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(4));
    else len = $urandom_range(45, 1);
    queue_frame(len, ihl, $urandom_range(2) == 0, pick >= 90);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || reply_words.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int items);
    int target;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = queued_cnt + items;
    while (queued_cnt < target) queue_random_frame();
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single odd word, junk byte counts, short frames with partial swaps
    queue_fill(1, 16'hFFFF, BV_TWO, BV_ONE);
    queue_fill(2, 16'h0000, BV_RSVD0, BV_RSVD3);
    queue_fill(4, 16'hA5C3, BV_TWO, BV_TWO);
    queue_fill(16, 16'h0000, BV_RSVD3, BV_TWO);
    wait_drained();

    run_phase(0, 0, 80);

    // hold the receiver off while requests keep coming
    hold_go = 1'b1;
    repeat (4) queue_frame(30, 5, 1'b0, 1'b0);
    wait_drained();

    run_phase(52, 0, 80);
    run_phase(0, 52, 80);
    run_phase(12, 12, 80);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
